@@ sv/apcr_pkg.sv @@
// shared types, constants and helpers of the page cache replacement unit
package apcr_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int PAGE_BYTES_DEF = 256;

  localparam int ADDR_W     = 20;
  localparam int STAMP_W    = 32;
  localparam int LFSR_W     = 16;
  localparam int OUT_SLOT_W = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int POLICY_W   = 2;
  localparam int ACTIVE_W   = 4;
  localparam int STORE_W    = 13;

  localparam logic [LFSR_W-1:0]   LFSR_MASK    = 16'hB400;
  localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'h0001;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;
  localparam logic [STORE_W-1:0]  STORE_RESET  = 13'd4096;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIFO   = 2'd0,
    POL_LRU    = 2'd1,
    POL_MRU    = 2'd2,
    POL_RANDOM = 2'd3
  } repl_policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_ACTIVE = 2'd1,
    CFG_STORE  = 2'd2
  } cfg_idx_t;

  // galois lfsr, shifts right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_MASK;
    end
    return s;
  endfunction

endpackage

@@ sv/apcr_if.sv @@
// access and result channel interfaces
interface apcr_in_if import apcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface apcr_out_if import apcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ADDR_W-1:0]     address_echo;
  logic                  hit;
  logic [OUT_SLOT_W-1:0] slot;
  logic                  evicted;
  logic                  status;

  modport source (output valid, output address_echo, output hit, output slot,
                  output evicted, output status, input ready);
  modport sink   (input valid, input address_echo, input hit, input slot,
                  input evicted, input status, output ready);
endinterface

@@ sv/apcr_ram.sv @@
// generic single-port-write ram with registered read
module apcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ sv/apcr_mod.sv @@
// iterative remainder unit, one quotient bit per cycle
module apcr_mod #(
  parameter int NW = 16,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] remainder
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] div_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] rem_nxt;
  logic [DW:0]   trial;

  always_comb begin
    trial = {rem_r, num_r[NW-1]};
    if (trial >= {1'b0, div_r}) begin
      trial = trial - {1'b0, div_r};
    end
    rem_nxt = trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done      = !busy_r;
  assign remainder = rem_r;
endmodule

@@ sv/assoc_page_cache_replacement_unit.sv @@
// top level: fully associative page cache tag store and replacement engine
// flow: the tag/stamp ram scan at one slot per cycle over the n active slots (n = active
//   slot count), then compare, decide and output steps; the output step holds while full
// random replacement also waits in the decide step for the remainder unit
// out-of-store page: skips the scan and goes straight to the output step; one transaction
//   in flight at a time, the next accepted in the cycle after the result loads
// reset (sync, rst_n low): config defaults, valid/fill/counter cleared, lfsr seeded, ram unreset
module assoc_page_cache_replacement_unit import apcr_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  apcr_in_if.sink               in_ch,
  apcr_out_if.source            out_ch
);
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int PAGE_W  = ADDR_W - PAGE_SH;
  localparam int RAM_W   = PAGE_W + STAMP_W;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LAST   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  repl_policy_t        cfg_policy_r;
  logic [ACTIVE_W-1:0] cfg_active_r;
  logic [STORE_W-1:0]  cfg_store_r;

  // cache bookkeeping kept in flops
  logic [SLOTS-1:0]   valid_r;
  logic [CNT_W-1:0]   fill_r;
  logic [STAMP_W-1:0] ctr_r;
  logic [LFSR_W-1:0]  lfsr_r;

  // current transaction
  logic [ADDR_W-1:0] addr_r;
  logic [PAGE_W-1:0] page_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              cmp_vld_r;
  logic              found_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [SLOT_W-1:0] best_idx_r;

  // pending result, then output register
  logic              res_hit_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_evict_r;
  logic              res_status_r;
  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic                  out_hit_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic                  out_evict_r;
  logic                  out_status_r;

  logic              in_acc;
  logic [PAGE_W-1:0] page_w;
  logic              err_w;
  logic [CNT_W-1:0]  n_w;
  logic              full_w;

  // ram ports
  logic              ram_we;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic [PAGE_W-1:0] rd_page;
  logic [STAMP_W-1:0] rd_stamp;

  // compare stage
  logic               cmp_match;
  logic [STAMP_W-1:0] cmp_stamp;
  logic               cmp_better;

  // decide step
  logic              dec_wait;
  logic              dec_fire;
  logic [SLOT_W-1:0] dec_slot;
  logic              dec_evict;
  logic              dec_replace;

  // output handoff
  logic out_free;
  logic out_load;

  // remainder unit for random victim choice
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign page_w = in_ch.address[ADDR_W-1:PAGE_SH];
  assign err_w  = (32'(page_w) >= 32'(cfg_store_r));

  // active slot count clamped to 1..SLOTS
  always_comb begin
    if (cfg_active_r == '0) begin
      n_w = CNT_W'(1);
    end else if (32'(cfg_active_r) > SLOTS) begin
      n_w = CNT_W'(SLOTS);
    end else begin
      n_w = CNT_W'(cfg_active_r);
    end
  end

  assign full_w = (fill_r >= n_w);

  // tag and stamp store, one word per slot
  apcr_ram #(
    .WIDTH(RAM_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(dec_slot),
    .wdata(ram_wdata),
    .re   (state_r == S_SCAN),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  assign rd_page  = ram_rdata[RAM_W-1:STAMP_W];
  assign rd_stamp = ram_rdata[STAMP_W-1:0];

  // lfsr value after one step is only committed on a random replacement
  apcr_mod #(
    .NW(LFSR_W),
    .DW(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (lfsr_step(lfsr_r)),
    .divisor  (n_w),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // compare the slot whose word just came out of the ram
  always_comb begin
    cmp_match = valid_r[cmp_idx_r] && (rd_page == page_r);
    cmp_stamp = valid_r[cmp_idx_r] ? rd_stamp : '0;
    if (cmp_idx_r == '0) begin
      cmp_better = 1'b1;
    end else if (cfg_policy_r == POL_MRU) begin
      cmp_better = (cmp_stamp > best_stamp_r);
    end else begin
      cmp_better = (cmp_stamp < best_stamp_r);
    end
  end

  // hit, fill of the next empty slot, or replacement of a victim
  always_comb begin
    dec_replace = !found_r && full_w;
    dec_wait    = (state_r == S_DECIDE) && dec_replace &&
                  (cfg_policy_r == POL_RANDOM) && !mod_done;
    dec_fire    = (state_r == S_DECIDE) && !dec_wait;
    if (found_r) begin
      dec_slot = hit_idx_r;
    end else if (!full_w) begin
      dec_slot = SLOT_W'(fill_r);
    end else if (cfg_policy_r == POL_RANDOM) begin
      dec_slot = SLOT_W'(mod_rem);
    end else begin
      dec_slot = best_idx_r;
    end
    dec_evict = dec_replace && valid_r[dec_slot];
    // hits refresh the stamp only under lru and mru
    ram_we    = dec_fire && (!found_r || cfg_policy_r == POL_LRU ||
                             cfg_policy_r == POL_MRU);
    ram_wdata = {page_r, ctr_r};
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_OUT) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = err_w ? S_OUT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (CNT_W'(rd_idx_r) + CNT_W'(1) == n_w) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (dec_fire) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_policy_r <= POL_FIFO;
      cfg_active_r <= ACTIVE_RESET;
      cfg_store_r  <= STORE_RESET;
      valid_r      <= '0;
      fill_r       <= '0;
      ctr_r        <= '0;
      lfsr_r       <= LFSR_SEED;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == S_SCAN);
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY: cfg_policy_r <= repl_policy_t'(cfg_wdata[POLICY_W-1:0]);
          CFG_ACTIVE: cfg_active_r <= cfg_wdata[ACTIVE_W-1:0];
          CFG_STORE:  cfg_store_r  <= cfg_wdata[STORE_W-1:0];
          default: begin
          end
        endcase
      end
      // counter moves on every access, errors included
      if (in_acc) begin
        ctr_r <= ctr_r + STAMP_W'(1);
      end
      if (dec_fire && !found_r) begin
        valid_r[dec_slot] <= 1'b1;
        if (!full_w) begin
          fill_r <= fill_r + CNT_W'(1);
        end
        if (full_w && cfg_policy_r == POL_RANDOM) begin
          lfsr_r <= lfsr_step(lfsr_r);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r       <= in_ch.address;
      page_r       <= page_w;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      res_hit_r    <= 1'b0;
      res_slot_r   <= '0;
      res_evict_r  <= 1'b0;
      res_status_r <= err_w;
    end
    if (state_r == S_SCAN) begin
      rd_idx_r  <= rd_idx_r + SLOT_W'(1);
      cmp_idx_r <= rd_idx_r;
    end
    if (cmp_vld_r) begin
      // first matching slot wins
      if (!found_r && cmp_match) begin
        found_r   <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      // strict compare keeps ties on the lowest slot
      if (cmp_better) begin
        best_stamp_r <= cmp_stamp;
        best_idx_r   <= cmp_idx_r;
      end
    end
    if (dec_fire) begin
      res_hit_r   <= found_r;
      res_slot_r  <= dec_slot;
      res_evict_r <= dec_evict;
    end
    if (out_load) begin
      out_addr_r   <= addr_r;
      out_hit_r    <= res_hit_r;
      out_slot_r   <= OUT_SLOT_W'(res_slot_r);
      out_evict_r  <= res_evict_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.address_echo = out_addr_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.evicted      = out_evict_r;
  assign out_ch.status       = out_status_r;

  // fill count never runs past the built slot count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= SLOTS)
    else $error("fill count beyond slot count");

  // an error transaction leaves the cache alone
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> !out_ch.hit && !out_ch.evicted)
    else $error("error result reports hit or eviction");

  // a hit never replaces a page
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> !out_ch.evicted)
    else $error("hit reports eviction");

  // lfsr must not lock up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("lfsr reached zero");

  // one transaction in flight: no acceptance right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while busy");
endmodule

@@ dv/assoc_page_cache_replacement_unit_tb.sv @@
// testbench of the page cache replacement unit: predicts every lookup and checks each result
`timescale 1ns / 100ps

module assoc_page_cache_replacement_unit_tb import apcr_pkg::*; ();

  // one expected lookup outcome, same fields as the result channel
  typedef struct packed {
    logic [ADDR_W-1:0]     address_echo;
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  evicted;
    logic                  status;
  } lookup_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  apcr_in_if  in_ch ();
  apcr_out_if out_ch ();

  assoc_page_cache_replacement_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // addresses waiting to be offered, and outcomes waiting on the result channel
  logic [ADDR_W-1:0] access_queue[$];
  lookup_result_t    outcomes_due[$];
  int                error_count;
  bit                calm;  // when set neither side idles

  // shadow copy of the cache state and registers
  repl_policy_t      cur_policy;
  logic [3:0]        cur_active;
  logic [12:0]       cur_store;
  bit                tag_valid[SLOTS_DEF];
  int unsigned       tag_page[SLOTS_DEF];
  logic [31:0]       tag_stamp[SLOTS_DEF];
  int unsigned       fill_level;
  logic [31:0]       access_count;
  logic [LFSR_W-1:0] victim_lfsr;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // next outcome of the cache for one access, updating the shadow state
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    int unsigned    pg;
    int unsigned    n;
    int unsigned    pick;
    bit             found;
    r = '0;
    r.address_echo = addr;
    pg = addr / PAGE_BYTES_DEF;
    // out-of-range active counts clamp to 1..SLOTS
    if (cur_active == 4'd0) n = 1;
    else if (cur_active > SLOTS_DEF) n = SLOTS_DEF;
    else n = cur_active;
    found = 1'b0;
    pick = 0;
    access_count = access_count + 32'd1;
    if (pg >= cur_store) begin
      // page not in the store: error status, tags and fill level unchanged
      r.status = 1'b1;
      return r;
    end
    for (int k = 0; k < n; k++) begin
      if (!found && tag_valid[k] && tag_page[k] == pg) begin
        found = 1'b1;
        pick = k;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (cur_policy == POL_LRU || cur_policy == POL_MRU) tag_stamp[pick] = access_count;
    end else begin
      if (fill_level < n) begin
        // empty slots fill in order
        pick = fill_level;
        fill_level++;
      end else if (cur_policy == POL_RANDOM) begin
        victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? LFSR_MASK : '0);
        pick = victim_lfsr % n;
      end else begin
        // lowest stamp for fifo and lru, highest for mru; ties keep the lower slot
        pick = 0;
        for (int k = 1; k < n; k++) begin
          if (cur_policy == POL_MRU ? (tag_stamp[k] > tag_stamp[pick])
                                    : (tag_stamp[k] < tag_stamp[pick])) pick = k;
        end
      end
      r.evicted = tag_valid[pick];
      tag_valid[pick] = 1'b1;
      tag_page[pick] = pg;
      tag_stamp[pick] = access_count;
    end
    r.slot = pick[OUT_SLOT_W-1:0];
    return r;
  endfunction

  // driver: offers queued addresses, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) outcomes_due.push_back(predict_lookup(in_ch.address));
      if (!in_ch.valid || in_ch.ready) begin
        if (access_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
          in_ch.valid   <= 1'b1;
          in_ch.address <= access_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // monitor: random back-pressure, compares each result transaction with the oldest outcome
  always @(posedge clk) begin
    lookup_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result with no access pending: address_echo %0h", out_ch.address_echo);
          error_count++;
        end else begin
          e = outcomes_due.pop_front();
          check_field("address_echo", 32'(e.address_echo), 32'(out_ch.address_echo));
          check_field("hit", 32'(e.hit), 32'(out_ch.hit));
          check_field("slot", 32'(e.slot), 32'(out_ch.slot));
          check_field("evicted", 32'(e.evicted), 32'(out_ch.evicted));
          check_field("status", 32'(e.status), 32'(out_ch.status));
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  // writes all three registers on consecutive edges; called at a rising edge while idle
  task automatic program_regs(input repl_policy_t pol, input logic [3:0] act,
                              input logic [12:0] store);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLICY;
    cfg_wdata <= CFG_DATA_W'(pol);
    @(posedge clk);
    cur_policy = pol;
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= CFG_DATA_W'(act);
    @(posedge clk);
    cur_active = act;
    cfg_index <= CFG_STORE;
    cfg_wdata <= store;
    @(posedge clk);
    cur_store = store;
    cfg_we <= 1'b0;
  endtask

  // waits until every queued access has its result, then lets the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (access_queue.size() != 0 || in_ch.valid || outcomes_due.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  function automatic void queue_page(input int unsigned pg, input int unsigned off);
    access_queue.push_back(ADDR_W'(pg * PAGE_BYTES_DEF + off));
  endfunction

  initial begin
    int unsigned  pool[$];
    int unsigned  store_eff;
    int unsigned  pg;
    int unsigned  n;
    int           r;
    repl_policy_t pol;
    logic [3:0]   act;
    logic [12:0]  store;

    // known values on every input before the first edge
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_POLICY;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.address = '0;
    out_ch.ready = 1'b0;
    calm         = 1'b0;
    error_count  = 0;

    // shadow state after reset
    cur_policy   = POL_FIFO;
    cur_active   = ACTIVE_RESET;
    cur_store    = STORE_RESET;
    fill_level   = 0;
    access_count = '0;
    victim_lfsr  = LFSR_SEED;
    for (int k = 0; k < SLOTS_DEF; k++) begin
      tag_valid[k] = 1'b0;
      tag_page[k]  = 0;
      tag_stamp[k] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // directed: fifo fill from empty, address extremes, first evictions
    program_regs(POL_FIFO, 4'd8, 13'd4096);
    access_queue.push_back(20'h00000);
    access_queue.push_back(20'hFFFFF);
    access_queue.push_back(20'h00180);
    access_queue.push_back(20'h000FF);
    for (int p = 2; p <= 6; p++) queue_page(p, p * 37);
    queue_page(7, 0);
    queue_page(0, 16);
    drain();

    // directed: mru victim, active count above the slot count, page just past the store
    program_regs(POL_MRU, 4'd15, 13'd16);
    access_queue.push_back(20'h00FFF);
    access_queue.push_back(20'h01000);
    access_queue.push_back(20'h00F00);
    access_queue.push_back(20'h00700);
    drain();

    // directed: empty store makes every access an error, active count of zero
    program_regs(POL_RANDOM, 4'd0, 13'd0);
    access_queue.push_back(20'h00000);
    access_queue.push_back(20'h80000);
    drain();

    // directed: random victims with the active count lowered below the fill level
    program_regs(POL_RANDOM, 4'd3, 13'd8191);
    queue_page(100, 1);
    queue_page(101, 2);
    queue_page(102, 3);
    queue_page(100, 4);
    queue_page(103, 5);
    drain();

    // directed: lru hit then replacement
    program_regs(POL_LRU, 4'd8, 13'd4096);
    queue_page(2, 9);
    queue_page(200, 0);
    queue_page(2, 255);
    queue_page(201, 128);
    drain();

    // random phases: first four at register extremes, then random settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        pol = repl_policy_t'(ph);
        case (ph)
          0: begin act = 4'd1;  store = 13'd4096; end
          1: begin act = 4'd8;  store = 13'd1;    end
          2: begin act = 4'd0;  store = 13'd8191; end
          default: begin act = 4'd15; store = 13'd0; end
        endcase
      end else begin
        pol = repl_policy_t'($urandom_range(0, 3));
        act = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
        store = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                            : 13'($urandom_range(16, 4096));
      end
      calm = (ph == 6 || ph == 7);
      program_regs(pol, act, store);

      // small pool of pages a bit larger than the active set gives hits and misses
      store_eff = (store > 4096) ? 4096 : store;
      n = (act == 4'd0) ? 1 : (act > SLOTS_DEF) ? SLOTS_DEF : act;
      pool.delete();
      for (int k = 0; k < n + $urandom_range(1, 4); k++) begin
        pool.push_back(store_eff == 0 ? $urandom_range(0, 4095) : $urandom_range(0, store_eff - 1));
      end
      for (int i = 0; i < 102; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          queue_page(pool[$urandom_range(0, pool.size() - 1)], $urandom_range(0, 255));
        end else if (r < 88) begin
          access_queue.push_back(ADDR_W'($urandom()));
        end else begin
          // page beyond the store where one exists
          pg = (store_eff < 4096) ? $urandom_range(store_eff, 4095) : $urandom_range(0, 4095);
          queue_page(pg, $urandom_range(0, 255));
        end
      end
      drain();
    end

    if (error_count == 0) begin
      $display("assoc_page_cache_replacement_unit_tb: done, clean");
    end else begin
      $display("assoc_page_cache_replacement_unit_tb: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("assoc_page_cache_replacement_unit_tb: done, errors");
    $finish;
  end

endmodule
